@@ rtl/dynamic_stall_aero_coefficients_macros.svh @@
// Assertion macros for the dynamic stall coefficient block.
// Included by the top level only; depends on nothing else.
`ifndef DYNAMIC_STALL_AERO_COEFFICIENTS_MACROS_SVH
`define DYNAMIC_STALL_AERO_COEFFICIENTS_MACROS_SVH

// Condition in the same cycle.
`define DSAC_ASSERT_IMPLY(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Condition in the following cycle.
`define DSAC_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/dsac_pkg.sv @@
// Shared types, step codes, constants and table builders for the dynamic stall block.
// Used by the controller, the datapath, the divider and the top level.
package dsac_pkg;

    localparam int STEP_W = 5;
    localparam int PHASE_W = 24;
    localparam int DIV_W = 38;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [STEP_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] ST_PHASE  = 5'd1;
    localparam logic [STEP_W-1:0] ST_SINTAB = 5'd2;
    localparam logic [STEP_W-1:0] ST_SININT = 5'd3;
    localparam logic [STEP_W-1:0] ST_CLSEP  = 5'd4;
    localparam logic [STEP_W-1:0] ST_TARG   = 5'd5;
    localparam logic [STEP_W-1:0] ST_TTAB   = 5'd6;
    localparam logic [STEP_W-1:0] ST_TINT   = 5'd7;
    localparam logic [STEP_W-1:0] ST_SEP1   = 5'd8;
    localparam logic [STEP_W-1:0] ST_SEP2   = 5'd9;
    localparam logic [STEP_W-1:0] ST_DLIFT  = 5'd10;
    localparam logic [STEP_W-1:0] ST_CL1    = 5'd11;
    localparam logic [STEP_W-1:0] ST_CL2    = 5'd12;
    localparam logic [STEP_W-1:0] ST_CD1    = 5'd13;
    localparam logic [STEP_W-1:0] ST_CD2    = 5'd14;
    localparam logic [STEP_W-1:0] ST_OMEGA  = 5'd15;
    localparam logic [STEP_W-1:0] ST_DIVGO  = 5'd16;
    localparam logic [STEP_W-1:0] ST_DIV    = 5'd17;
    localparam logic [STEP_W-1:0] ST_CM1    = 5'd18;
    localparam logic [STEP_W-1:0] ST_CM2    = 5'd19;
    localparam logic [STEP_W-1:0] ST_PUT    = 5'd20;

    localparam logic [2:0] REG_ZERO_LIFT  = 3'd0;
    localparam logic [2:0] REG_STALL_UP   = 3'd1;
    localparam logic [2:0] REG_STALL_DOWN = 3'd2;
    localparam logic [2:0] REG_INV_WIDTH  = 3'd3;
    localparam logic [2:0] REG_INV_TAU_S  = 3'd4;
    localparam logic [2:0] REG_INV_TAU_A  = 3'd5;
    localparam logic [2:0] REG_MAX_LIFT   = 3'd6;
    localparam logic [2:0] REG_CHORD      = 3'd7;

    localparam logic signed [47:0] OUT_MAX = 48'sd8388607;
    localparam logic signed [47:0] OUT_MIN = -48'sd8388608;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              load;
        logic              div_start;
        logic              put;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > OUT_MAX) return 24'sd8388607;
        if (v < OUT_MIN) return -24'sd8388608;
        return 24'(v);
    endfunction

    function automatic logic ovf24(input logic signed [47:0] v);
        return (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

    function automatic longint sin_q30(input longint x);
        longint x2, term, sum;
        x2 = (x * x) / ONE_Q30;
        term = x;
        sum = x;
        term = (term * x2) / ONE_Q30; term = -term / 6;   sum += term;
        term = (term * x2) / ONE_Q30; term = -term / 20;  sum += term;
        term = (term * x2) / ONE_Q30; term = -term / 42;  sum += term;
        term = (term * x2) / ONE_Q30; term = -term / 72;  sum += term;
        term = (term * x2) / ONE_Q30; term = -term / 110; sum += term;
        term = (term * x2) / ONE_Q30; term = -term / 156; sum += term;
        return sum;
    endfunction

    function automatic longint expneg_q30(input longint z);
        longint term, sum;
        term = ONE_Q30;
        sum = ONE_Q30;
        term = (term * z) / ONE_Q30; term = -term / 1;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 2;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 3;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 4;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 5;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 6;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 7;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 8;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 9;  sum += term;
        term = (term * z) / ONE_Q30; term = -term / 10; sum += term;
        term = (term * z) / ONE_Q30; term = -term / 11; sum += term;
        term = (term * z) / ONE_Q30; term = -term / 12; sum += term;
        return sum;
    endfunction

    function automatic longint sin_tab_entry(input int k, input int bits);
        longint n, m, v;
        logic   neg;
        n = longint'(1) <<< bits;
        if (k <= (n >>> 2)) begin
            m = k;
            neg = 1'b0;
        end else if (k <= (n >>> 1)) begin
            m = (n >>> 1) - k;
            neg = 1'b0;
        end else if (k <= 3 * (n >>> 2)) begin
            m = k - (n >>> 1);
            neg = 1'b1;
        end else begin
            m = n - k;
            neg = 1'b1;
        end
        v = sin_q30((m * TWO_PI_Q30) >>> bits);
        if (v < 0) v = 0;
        v = (v + 8192) >>> 14;
        return neg ? -v : v;
    endfunction

    function automatic longint tanh_exp(input int k, input int bits);
        longint e;
        e = expneg_q30(longint'(k) <<< (30 - bits));
        e = (e * e) >>> 30;
        e = (e * e) >>> 30;
        e = (e * e) >>> 30;
        e = (e * e) >>> 30;
        return e;
    endfunction

    function automatic longint tanh_num(input int k, input int bits);
        longint e;
        e = tanh_exp(k, bits);
        return (ONE_Q30 - e) * 131072 + (ONE_Q30 + e);
    endfunction

    function automatic longint tanh_den(input int k, input int bits);
        longint e;
        e = tanh_exp(k, bits);
        return 2 * (ONE_Q30 + e);
    endfunction

endpackage

@@ rtl/dsac_div.sv @@
// Restoring divider, one quotient bit per cycle, for the pitch rate term.
// Depends on dsac_pkg for the dividend width.
module dsac_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dsac_pkg::DIV_W-1:0]   dividend,
    input  logic [15:0]                  divisor,
    output logic                         done,
    output logic [dsac_pkg::DIV_W-1:0]   quotient
);

    logic [dsac_pkg::DIV_W-1:0]     quo_reg;
    logic [15:0]                    rem_reg;
    logic [dsac_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [16:0]                    trial;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[dsac_pkg::DIV_W-1]};
    assign fits = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= dsac_pkg::DIV_CNT_W'(dsac_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - dsac_pkg::DIV_CNT_W'(1);
                if (cnt_reg == dsac_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[dsac_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/dsac_ctrl.sv @@
// Sequencer for the dynamic stall block: steps the datapath and runs both handshakes.
// Depends on dsac_pkg for step codes and the command and status types.
module dsac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dsac_pkg::status_t status,
    output dsac_pkg::cmd_t    cmd
);

    logic [dsac_pkg::STEP_W-1:0] state_reg, state_next;
    logic                        m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.step = state_reg;
        unique case (state_reg)
            dsac_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = dsac_pkg::ST_PHASE;
                end
            end
            dsac_pkg::ST_PHASE:  state_next = dsac_pkg::ST_SINTAB;
            dsac_pkg::ST_SINTAB: state_next = dsac_pkg::ST_SININT;
            dsac_pkg::ST_SININT: state_next = dsac_pkg::ST_CLSEP;
            dsac_pkg::ST_CLSEP:  state_next = dsac_pkg::ST_TARG;
            dsac_pkg::ST_TARG:   state_next = dsac_pkg::ST_TTAB;
            dsac_pkg::ST_TTAB:   state_next = dsac_pkg::ST_TINT;
            dsac_pkg::ST_TINT:   state_next = dsac_pkg::ST_SEP1;
            dsac_pkg::ST_SEP1:   state_next = dsac_pkg::ST_SEP2;
            dsac_pkg::ST_SEP2:   state_next = dsac_pkg::ST_DLIFT;
            dsac_pkg::ST_DLIFT:  state_next = dsac_pkg::ST_CL1;
            dsac_pkg::ST_CL1:    state_next = dsac_pkg::ST_CL2;
            dsac_pkg::ST_CL2:    state_next = dsac_pkg::ST_CD1;
            dsac_pkg::ST_CD1:    state_next = dsac_pkg::ST_CD2;
            dsac_pkg::ST_CD2:    state_next = dsac_pkg::ST_OMEGA;
            dsac_pkg::ST_OMEGA:  state_next = dsac_pkg::ST_DIVGO;
            dsac_pkg::ST_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next = dsac_pkg::ST_DIV;
            end
            dsac_pkg::ST_DIV: begin
                if (status.div_done) state_next = dsac_pkg::ST_CM1;
            end
            dsac_pkg::ST_CM1:    state_next = dsac_pkg::ST_CM2;
            dsac_pkg::ST_CM2:    state_next = dsac_pkg::ST_PUT;
            dsac_pkg::ST_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.put = 1'b1;
                    state_next = dsac_pkg::ST_IDLE;
                end
            end
            default: state_next = dsac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.put) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsac_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == dsac_pkg::ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/dsac_dp.sv @@
// Datapath for the dynamic stall block: registers, tables, one shared multiplier.
// Depends on dsac_pkg and instantiates the divider dsac_div.
module dsac_dp #(
    parameter int TRIG_TABLE_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dsac_pkg::cmd_t      cmd,
    output dsac_pkg::status_t   status,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic signed [15:0]  s_angle_of_attack,
    input  logic signed [15:0]  s_elevator_deflection,
    input  logic signed [15:0]  s_pitch_rate,
    input  logic [15:0]         s_airspeed,
    input  logic [15:0]         s_time_step,
    output logic signed [23:0]  m_lift_coeff,
    output logic signed [23:0]  m_drag_coeff,
    output logic signed [23:0]  m_moment_coeff,
    output logic [16:0]         m_separation_out,
    output logic                m_saturated
);

    localparam int TB = TRIG_TABLE_BITS;
    localparam int FS = dsac_pkg::PHASE_W - TB;
    localparam int N = 1 << TB;
    localparam logic signed [62:0] FRND = 63'sd1 <<< (FS - 1);
    localparam logic signed [41:0] RATE_FULL = 42'sd1099511627776;

    logic signed [17:0] sin_tab [0:N];
    logic signed [17:0] tanh_tab [0:N];

    for (genvar k = 0; k <= N; k++) begin : g_tab
        localparam longint SVAL = dsac_pkg::sin_tab_entry(k, TB);
        localparam longint TNUM = dsac_pkg::tanh_num(k, TB);
        localparam longint TDEN = dsac_pkg::tanh_den(k, TB);
        localparam longint TVAL = TNUM / TDEN;
        assign sin_tab[k] = 18'(SVAL);
        assign tanh_tab[k] = 18'(TVAL);
    end

    logic signed [15:0] zla_reg, up_reg, down_reg;
    logic [15:0]        inv_w_reg, inv_ts_reg, inv_ta_reg, chord_reg;
    logic [14:0]        max_lift_reg;

    logic signed [15:0] alpha_reg, delta_reg, omega_reg;
    logic [15:0]        speed_reg, dt_reg;
    logic signed [16:0] da_reg;
    logic [dsac_pkg::PHASE_W-1:0] phase_reg;
    logic signed [17:0] sa_reg, sin_reg, ta_reg;
    logic signed [18:0] sdiff_reg, tdiff_reg;
    logic signed [21:0] clsep_reg;
    logic signed [33:0] targ_reg, p1_reg;
    logic [FS-1:0]      tfr_reg;
    logic               tbig_reg, tneg_reg;
    logic [16:0]        xeq_reg, sep_reg;
    logic signed [23:0] clatt_reg, cl_reg, cd_reg, cm_reg;
    logic signed [41:0] acc_reg;
    logic signed [35:0] t35_reg;
    logic signed [38:0] num_reg;
    logic signed [43:0] cmacc_reg;
    logic               flag_reg;

    logic signed [23:0] lift_reg, drag_reg, moment_reg;
    logic [16:0]        sep_out_reg;
    logic               sat_reg;

    logic signed [35:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [62:0] prod;

    logic [TB-1:0]      sidx, tidx;
    logic [TB:0]        sidx1, tidx1;
    logic [33:0]        tmag;
    logic signed [62:0] fsh;
    logic signed [18:0] tint, tsig;
    logic signed [19:0] xsum;
    logic signed [17:0] sepdiff, oms;
    logic signed [62:0] sstep;
    logic signed [27:0] nsep;
    logic               upd_up, upd_dn;
    logic signed [43:0] clsum, clr;
    logic signed [24:0] abscl;
    logic signed [62:0] cdq;
    logic [16:0]        sepq;
    logic signed [47:0] cdw;
    logic [38:0]        numabs;
    logic [dsac_pkg::DIV_W-1:0] dividend, quotient;
    logic               div_done;
    logic signed [41:0] rate;
    logic signed [43:0] cmw;

    dsac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (speed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zla_reg <= -16'sd287;
            up_reg <= 16'sd2288;
            down_reg <= 16'sd1716;
            inv_w_reg <= 16'd4889;
            inv_ts_reg <= 16'd1707;
            inv_ta_reg <= 16'd427;
            max_lift_reg <= 15'd5939;
            chord_reg <= 16'd256;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dsac_pkg::REG_ZERO_LIFT:  zla_reg <= cfg_wr_data;
                dsac_pkg::REG_STALL_UP:   up_reg <= cfg_wr_data;
                dsac_pkg::REG_STALL_DOWN: down_reg <= cfg_wr_data;
                dsac_pkg::REG_INV_WIDTH:  inv_w_reg <= cfg_wr_data;
                dsac_pkg::REG_INV_TAU_S:  inv_ts_reg <= cfg_wr_data;
                dsac_pkg::REG_INV_TAU_A:  inv_ta_reg <= cfg_wr_data;
                dsac_pkg::REG_MAX_LIFT:   max_lift_reg <= cfg_wr_data[14:0];
                dsac_pkg::REG_CHORD:      chord_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign upd_up = alpha_reg > up_reg;
    assign upd_dn = alpha_reg < down_reg;
    assign sepdiff = $signed({1'b0, xeq_reg}) - $signed({1'b0, sep_reg});
    assign oms = 18'sd65536 - $signed({1'b0, sep_reg});
    assign abscl = cl_reg[23] ? -25'(cl_reg) : 25'(cl_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            dsac_pkg::ST_PHASE: begin
                mul_a = 36'($signed({alpha_reg, 1'b0}));
                mul_b = 27'sd21361414;
            end
            dsac_pkg::ST_SININT: begin
                mul_a = 36'(sdiff_reg);
                mul_b = 27'($signed({1'b0, phase_reg[FS-1:0]}));
            end
            dsac_pkg::ST_CLSEP: begin
                mul_a = 36'(sin_reg);
                mul_b = 27'($signed({1'b0, max_lift_reg}));
            end
            dsac_pkg::ST_TARG: begin
                mul_a = 36'(17'(alpha_reg) - 17'(up_reg));
                mul_b = 27'($signed({1'b0, inv_w_reg}));
            end
            dsac_pkg::ST_TINT: begin
                mul_a = 36'(tdiff_reg);
                mul_b = 27'($signed({1'b0, tfr_reg}));
            end
            dsac_pkg::ST_SEP1: begin
                mul_a = 36'(sepdiff);
                mul_b = 27'($signed({1'b0, dt_reg}));
            end
            dsac_pkg::ST_SEP2: begin
                mul_a = 36'(p1_reg);
                mul_b = upd_up ? 27'($signed({1'b0, inv_ts_reg}))
                               : 27'($signed({1'b0, inv_ta_reg}));
            end
            dsac_pkg::ST_DLIFT: begin
                mul_a = 36'(delta_reg);
                mul_b = 27'sd28836;
            end
            dsac_pkg::ST_CL1: begin
                mul_a = 36'(clatt_reg);
                mul_b = 27'(oms);
            end
            dsac_pkg::ST_CL2: begin
                mul_a = 36'(clsep_reg);
                mul_b = 27'($signed({1'b0, sep_reg}));
            end
            dsac_pkg::ST_CD1: begin
                mul_a = 36'(abscl);
                mul_b = 27'sd3604;
            end
            dsac_pkg::ST_CD2: begin
                mul_a = t35_reg;
                mul_b = 27'(abscl);
            end
            dsac_pkg::ST_OMEGA: begin
                mul_a = 36'(omega_reg);
                mul_b = 27'($signed({1'b0, chord_reg}));
            end
            dsac_pkg::ST_CM1: begin
                mul_a = 36'(delta_reg);
                mul_b = 27'sd95683;
            end
            dsac_pkg::ST_CM2: begin
                mul_a = 36'($signed({1'b0, sep_reg}));
                mul_b = 27'sd39322;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    assign sidx = phase_reg[dsac_pkg::PHASE_W-1:FS];
    assign sidx1 = {1'b0, sidx} + (TB + 1)'(1);
    assign tmag = targ_reg[33] ? 34'(-targ_reg) : 34'(targ_reg);
    assign tidx = tmag[dsac_pkg::PHASE_W-1:FS];
    assign tidx1 = {1'b0, tidx} + (TB + 1)'(1);
    assign fsh = (prod + FRND) >>> FS;

    assign tint = tbig_reg ? 19'sd65536 : 19'(ta_reg) + 19'(fsh);
    assign tsig = tneg_reg ? -tint : tint;
    assign xsum = 20'(tsig) + 20'sd65537;

    assign sstep = (prod + (63'sd1 <<< 23)) >>> 24;
    assign nsep = 28'($signed({1'b0, sep_reg})) + 28'(sstep);

    assign clsum = 44'(acc_reg) + 44'(prod);
    assign clr = (clsum + 44'sd32768) >>> 16;

    assign cdq = (prod + (63'sd1 <<< 31)) >>> 32;
    assign sepq = 17'(({1'b0, sep_reg} + 18'd2) >> 2);
    assign cdw = 48'sd1147 + 48'(cdq) + 48'($signed({1'b0, sepq}));

    assign numabs = num_reg[38] ? 39'(-num_reg) : 39'(num_reg);
    assign dividend = dsac_pkg::DIV_W'(numabs) + dsac_pkg::DIV_W'(speed_reg[15:1]);

    always_comb begin
        if (speed_reg == 16'd0) begin
            if (num_reg > 39'sd0) rate = RATE_FULL;
            else if (num_reg < 39'sd0) rate = -RATE_FULL;
            else rate = '0;
        end else if (num_reg[38]) begin
            rate = -42'($signed({1'b0, quotient}));
        end else begin
            rate = 42'($signed({1'b0, quotient}));
        end
    end

    assign cmw = cmacc_reg - 44'((prod + 63'sd32768) >>> 16);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            alpha_reg <= s_angle_of_attack;
            delta_reg <= s_elevator_deflection;
            omega_reg <= s_pitch_rate;
            speed_reg <= s_airspeed;
            dt_reg <= s_time_step;
            flag_reg <= 1'b0;
        end
        unique case (cmd.step)
            dsac_pkg::ST_PHASE: begin
                phase_reg <= dsac_pkg::PHASE_W'((prod + 63'sd32768) >>> 16);
                da_reg <= 17'(alpha_reg) - 17'(zla_reg);
            end
            dsac_pkg::ST_SINTAB: begin
                sa_reg <= sin_tab[{1'b0, sidx}];
                sdiff_reg <= 19'(sin_tab[sidx1]) - 19'(sin_tab[{1'b0, sidx}]);
            end
            dsac_pkg::ST_SININT: sin_reg <= 18'(19'(sa_reg) + 19'(fsh));
            dsac_pkg::ST_CLSEP: clsep_reg <= 22'((prod + 63'sd2048) >>> 12);
            dsac_pkg::ST_TARG: targ_reg <= 34'(prod);
            dsac_pkg::ST_TTAB: begin
                tneg_reg <= targ_reg[33];
                tbig_reg <= |tmag[33:dsac_pkg::PHASE_W];
                tfr_reg <= tmag[FS-1:0];
                ta_reg <= tanh_tab[{1'b0, tidx}];
                tdiff_reg <= 19'(tanh_tab[tidx1]) - 19'(tanh_tab[{1'b0, tidx}]);
            end
            dsac_pkg::ST_TINT: xeq_reg <= 17'(xsum >>> 1);
            dsac_pkg::ST_SEP1: p1_reg <= 34'(prod);
            dsac_pkg::ST_DLIFT: begin
                clatt_reg <= (24'(da_reg) <<< 5) + (24'(da_reg) <<< 3)
                             + 24'((prod + 63'sd4096) >>> 13);
            end
            dsac_pkg::ST_CL1: acc_reg <= 42'(prod);
            dsac_pkg::ST_CL2: begin
                cl_reg <= dsac_pkg::sat24(48'(clr));
                flag_reg <= flag_reg | dsac_pkg::ovf24(48'(clr));
            end
            dsac_pkg::ST_CD1: t35_reg <= 36'(prod);
            dsac_pkg::ST_CD2: begin
                cd_reg <= dsac_pkg::sat24(cdw);
                flag_reg <= flag_reg | dsac_pkg::ovf24(cdw);
            end
            dsac_pkg::ST_OMEGA: num_reg <= (39'(prod) <<< 5) + (39'(prod) <<< 4);
            dsac_pkg::ST_CM1: begin
                cmacc_reg <= -44'sd6554 - (44'(da_reg) <<< 3)
                             - 44'((prod + 63'sd4096) >>> 13) - 44'(rate);
                flag_reg <= flag_reg | (speed_reg == 16'd0);
            end
            dsac_pkg::ST_CM2: begin
                cm_reg <= dsac_pkg::sat24(48'(cmw));
                flag_reg <= flag_reg | dsac_pkg::ovf24(48'(cmw));
            end
            default: ;
        endcase
        if (cmd.put) begin
            lift_reg <= cl_reg;
            drag_reg <= cd_reg;
            moment_reg <= cm_reg;
            sep_out_reg <= sep_reg;
            sat_reg <= flag_reg;
        end
    end

    // The separation fraction is the only state kept from item to item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= '0;
        end else if (cmd.step == dsac_pkg::ST_SEP2 && (upd_up || upd_dn)) begin
            if (nsep < 28'sd0) sep_reg <= '0;
            else if (nsep > 28'sd65536) sep_reg <= 17'd65536;
            else sep_reg <= 17'(nsep);
        end
    end

    assign m_lift_coeff = lift_reg;
    assign m_drag_coeff = drag_reg;
    assign m_moment_coeff = moment_reg;
    assign m_separation_out = sep_out_reg;
    assign m_saturated = sat_reg;

endmodule

@@ rtl/dynamic_stall_aero_coefficients.sv @@
// The block takes one item at a time and accepts the next only after the last result
// is put in the output register. The 38-step divider serves the pitch rate term, and
// the shared multiplier takes one step each for the other products.
// A finished result waits in the output register while the next item is accepted.
// Reset (aresetn, synchronous, active low) clears the separation fraction to zero,
// loads the register defaults and empties the output.
`include "dynamic_stall_aero_coefficients_macros.svh"

module dynamic_stall_aero_coefficients #(
    parameter int TRIG_TABLE_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_angle_of_attack,
    input  logic signed [15:0] s_elevator_deflection,
    input  logic signed [15:0] s_pitch_rate,
    input  logic [15:0]        s_airspeed,
    input  logic [15:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_lift_coeff,
    output logic signed [23:0] m_drag_coeff,
    output logic signed [23:0] m_moment_coeff,
    output logic [16:0]        m_separation_out,
    output logic               m_saturated
);

    dsac_pkg::cmd_t    cmd;
    dsac_pkg::status_t status;

    dsac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsac_dp #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wr_data           (cfg_wr_data),
        .s_angle_of_attack     (s_angle_of_attack),
        .s_elevator_deflection (s_elevator_deflection),
        .s_pitch_rate          (s_pitch_rate),
        .s_airspeed            (s_airspeed),
        .s_time_step           (s_time_step),
        .m_lift_coeff          (m_lift_coeff),
        .m_drag_coeff          (m_drag_coeff),
        .m_moment_coeff        (m_moment_coeff),
        .m_separation_out      (m_separation_out),
        .m_saturated           (m_saturated)
    );

    `DSAC_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while an item is in work")
    `DSAC_ASSERT_IMPLY(a_separation_range, aclk, aresetn, m_valid, m_separation_out <= 17'd65536, "separation fraction above one")
    `DSAC_ASSERT_IMPLY(a_drag_positive, aclk, aresetn, m_valid, !m_drag_coeff[23], "drag coefficient negative")

endmodule
